### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, sizes and helpers of the sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int MEDIAN_WIDTH = 32;
	localparam int CFG_WIDTH    = 7;
	localparam int AGE_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [MEDIAN_WIDTH-1:0] median_t;
	typedef logic [AGE_W-1:0]               age_t;
	typedef logic [CNT_W-1:0]               cnt_t;
	typedef logic [CFG_WIDTH-1:0]           cfg_t;

	localparam cfg_t WINDOW_RESET = CFG_WIDTH'(3);

	typedef struct packed {
		logic step;
		logic flush;
	} swm_ctrl_t;

	typedef struct packed {
		logic   hit;
		median_t median;
	} swm_stat_t;

	function automatic cnt_t clamp_window(input cfg_t w);
		cnt_t k;
		if (w == '0)
			k = CNT_W'(1);
		else if (int'(w) > MAX_WINDOW)
			k = CNT_W'(MAX_WINDOW);
		else
			k = CNT_W'(w);
		return k;
	endfunction

endpackage

`default_nettype wire

### sv/swm_stream_if.sv
// ----------------------------------------------------------------------------
// swm_stream_if
// Valid/ready channels for the sample stream and the median stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_sample_if;
	import swm_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if;
	import swm_pkg::*;
	logic    valid;
	logic    ready;
	median_t median;
	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

### sv/swm_sorter.sv
// ----------------------------------------------------------------------------
// swm_sorter
// Sorted window of age-marked cells with parallel drop, compare and insert.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_sorter (
	input  logic              clk,
	input  logic              arst_n,
	input  swm_pkg::swm_ctrl_t ctrl,
	input  swm_pkg::cnt_t      k,
	input  swm_pkg::sample_t   sample,
	output swm_pkg::swm_stat_t stat
);
	import swm_pkg::*;

	sample_t val_q [MAX_WINDOW];
	age_t    age_q [MAX_WINDOW];
	cnt_t    fill_q;

	logic    full;
	cnt_t    k_last;
	cnt_t    mid;
	cnt_t    rm_idx;
	cnt_t    fill_r;
	cnt_t    fill_n;

	logic    le_x  [MAX_WINDOW+1];
	sample_t val_x [MAX_WINDOW+1];
	age_t    age_x [MAX_WINDOW+1];

	sample_t cv    [MAX_WINDOW];
	age_t    ca    [MAX_WINDOW];
	logic    cle   [MAX_WINDOW];
	sample_t cv_p  [MAX_WINDOW+1];
	age_t    ca_p  [MAX_WINDOW+1];
	logic    cle_p [MAX_WINDOW+1];

	sample_t nv    [MAX_WINDOW];
	age_t    na    [MAX_WINDOW];

	always_comb begin
		full   = (fill_q == k);
		k_last = k - CNT_W'(1);
		mid    = k_last >> 1;
		rm_idx = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			val_x[i] = val_q[i];
			age_x[i] = age_q[i];
			le_x[i]  = (val_q[i] <= sample);
			if ((CNT_W'(i) < fill_q) && (age_q[i] == AGE_W'(k_last)))
				rm_idx = rm_idx | CNT_W'(i);
		end
		val_x[MAX_WINDOW] = '0;
		age_x[MAX_WINDOW] = '0;
		le_x[MAX_WINDOW]  = 1'b0;
		if (!full)
			rm_idx = CNT_W'(MAX_WINDOW);
		fill_r = full ? (fill_q - CNT_W'(1)) : fill_q;
		fill_n = fill_r + CNT_W'(1);

		cv_p[0]  = sample;
		ca_p[0]  = '0;
		cle_p[0] = 1'b1;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (CNT_W'(j) >= rm_idx) begin
				cv[j]  = val_x[j+1];
				ca[j]  = age_x[j+1];
				cle[j] = (CNT_W'(j) < fill_r) && le_x[j+1];
			end else begin
				cv[j]  = val_x[j];
				ca[j]  = age_x[j];
				cle[j] = (CNT_W'(j) < fill_r) && le_x[j];
			end
			cv_p[j+1]  = cv[j];
			ca_p[j+1]  = ca[j];
			cle_p[j+1] = cle[j];
		end

		for (int j = 0; j < MAX_WINDOW; j++) begin
			if (cle[j]) begin
				nv[j] = cv[j];
				na[j] = ca[j] + AGE_W'(1);
			end else if (cle_p[j]) begin
				nv[j] = sample;
				na[j] = '0;
			end else begin
				nv[j] = cv_p[j];
				na[j] = ca_p[j] + AGE_W'(1);
			end
		end

		stat.hit    = ctrl.step && !ctrl.flush && (fill_n == k);
		stat.median = MEDIAN_WIDTH'(nv[mid[AGE_W-1:0]]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.flush) begin
			fill_q <= '0;
		end else if (ctrl.step) begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			for (int j = 0; j < MAX_WINDOW; j++) begin
				val_q[j] <= nv[j];
				age_q[j] <= na[j];
			end
		end
	end

endmodule

`default_nettype wire

### sv/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running lower median over the most recent window_size samples.
// ----------------------------------------------------------------------------
//  channel      role    payload            accepted when
//  sample_bus   sink    sample (32, s)     valid & ready
//  median_bus   source  median (32, s)     valid & ready
//  cfg_we/wdata write   window_size (7, u) cfg_we
//
//  One item per cycle while the output is not stalled; an item is held in
//  the input stage, its result in the median register. The sorter's
//  combinational drop, compare and insert across all cells sets the rate.
//  Reset sets the window to 3 and empties the fill count; no clearing pass.
//  A stalled result holds the input stage; input stalls only then.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_top (
	input  logic            clk,
	input  logic            arst_n,
	swm_sample_if.sink      sample_bus,
	swm_median_if.source    median_bus,
	input  logic            cfg_we,
	input  swm_pkg::cfg_t   cfg_wdata
);
	import swm_pkg::*;

	cfg_t      window_q;
	logic      valid_s1;
	sample_t   sample_s1;
	logic      out_valid_q;
	median_t   median_q;

	logic      advance;
	logic      accept;
	swm_ctrl_t ctrl;
	swm_stat_t stat;

	assign advance          = valid_s1 && (!out_valid_q || median_bus.ready);
	assign sample_bus.ready = !valid_s1 || advance;
	assign accept           = sample_bus.valid && sample_bus.ready;
	assign ctrl             = '{step: advance, flush: cfg_we};

	assign median_bus.valid  = out_valid_q;
	assign median_bus.median = median_q;

	swm_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.k      (clamp_window(window_q)),
		.sample (sample_s1),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				window_q <= cfg_wdata;
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= stat.hit;
			else if (median_bus.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			sample_s1 <= sample_bus.sample;
		if (advance && stat.hit)
			median_q <= stat.median;
	end

endmodule

`default_nettype wire

### sv/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input swm_pkg::median_t median,
	input logic             cfg_we
);
	import swm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median))
		else $error("stalled result changed");

	a_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	a_flush_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(cfg_we))
		else $error("result issued across a window write");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_bus.valid),
	.in_ready  (sample_bus.ready),
	.out_valid (median_bus.valid),
	.out_ready (median_bus.ready),
	.median    (median_bus.median),
	.cfg_we    (cfg_we)
);

`default_nettype wire
